// ----- hdl/swmm_pkg.sv -----
// swmm_pkg: shared types and constants for the sliding window min/max block
// used by swmm_cell and sliding_window_min_max; no dependencies
package swmm_pkg;

	localparam int MAX_WINDOW_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int WINDOW_W    = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = CFG_INDEX_W'(1);

	typedef enum logic {
		MODE_MIN = 1'b0,
		MODE_MAX = 1'b1
	} mode_t;

	typedef struct packed {
		logic  load;
		logic  start;
		mode_t mode;
	} cell_ctrl_t;

endpackage

// ----- hdl/swmm_cell.sv -----
// swmm_cell: one cell of the candidate row, holds the sample of one age
// and its candidate flag; uses swmm_pkg
module swmm_cell #(
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WIN_W        = 7,
	parameter int IDX          = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmm_pkg::cell_ctrl_t           ctrl,
	input  logic [WIN_W-1:0]               win,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] d_val,
	input  logic                           d_cand,
	input  logic                           kill_in,
	output logic                           kill_out,
	output logic signed [SAMPLE_WIDTH-1:0] nxt_val,
	output logic                           nxt_cand,
	output logic signed [SAMPLE_WIDTH-1:0] val,
	output logic                           cand
);

	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic                           cand_q;
	logic                           expired;
	logic                           live;
	logic                           dom;

	// age of this cell relative to the incoming sample is IDX + 1
	assign expired  = (32'(win) <= IDX + 1);
	assign live     = cand_q && !expired && !ctrl.start;
	assign dom      = (ctrl.mode == swmm_pkg::MODE_MAX) ? (val_q <= sample) : (val_q >= sample);
	assign nxt_cand = live && !(dom && kill_in);
	assign kill_out = kill_in && (!live || dom);
	assign nxt_val  = val_q;
	assign val      = val_q;
	assign cand     = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (ctrl.load) begin
			cand_q <= d_cand;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= d_val;
		end
	end

endmodule

// ----- hdl/swmm_tree.sv -----
// swmm_tree: registered select tree that picks the oldest flagged cell
// one register level per tree level; uses no package items
module swmm_tree #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int LEVELS       = 6,
	parameter int LEAVES       = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic                           in_rv,
	input  logic                           leaf_flag [LEAVES],
	input  logic signed [SAMPLE_WIDTH-1:0] leaf_val  [LEAVES],
	output logic                           out_vld,
	output logic                           out_rv,
	output logic signed [SAMPLE_WIDTH-1:0] out_val
);

	logic                           src_f [LEVELS][LEAVES];
	logic signed [SAMPLE_WIDTH-1:0] src_v [LEVELS][LEAVES];
	logic                           r_f   [1:LEVELS][LEAVES];
	logic signed [SAMPLE_WIDTH-1:0] r_v   [1:LEVELS][LEAVES];
	logic                           vld_q [1:LEVELS];
	logic                           rv_q  [1:LEVELS];

	always_comb begin
		for (int k = 0; k < LEAVES; k++) begin
			src_f[0][k] = leaf_flag[k];
			src_v[0][k] = leaf_val[k];
		end
		for (int l = 1; l < LEVELS; l++) begin
			for (int k = 0; k < LEAVES; k++) begin
				src_f[l][k] = r_f[l][k];
				src_v[l][k] = r_v[l][k];
			end
		end
	end

	// higher index holds the older sample
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 1; l <= LEVELS; l++) begin
				for (int k = 0; k < LEAVES; k++) begin
					if (k < (LEAVES >> l)) begin
						if (src_f[l-1][2*k+1]) begin
							r_f[l][k] <= 1'b1;
							r_v[l][k] <= src_v[l-1][2*k+1];
						end else begin
							r_f[l][k] <= src_f[l-1][2*k];
							r_v[l][k] <= src_v[l-1][2*k];
						end
					end else begin
						r_f[l][k] <= 1'b0;
						r_v[l][k] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 1; l <= LEVELS; l++) begin
				vld_q[l] <= 1'b0;
			end
		end else if (en) begin
			vld_q[1] <= in_vld;
			for (int l = 2; l <= LEVELS; l++) begin
				vld_q[l] <= vld_q[l-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv_q[1] <= in_rv;
			for (int l = 2; l <= LEVELS; l++) begin
				rv_q[l] <= rv_q[l-1];
			end
		end
	end

	assign out_vld = vld_q[LEVELS];
	assign out_rv  = rv_q[LEVELS];
	assign out_val = rv_q[LEVELS] ? r_v[LEVELS][0] : '0;

endmodule

// ----- hdl/sliding_window_min_max.sv -----
// sliding_window_min_max: top level, config registers, cell row and select tree
// depends on swmm_pkg, swmm_cell and swmm_tree
//
// Takes one signed sample per cycle and returns, for every sample, the minimum
// (mode 0) or maximum (mode 1) of the last window_length samples of the series.
// A row of MAX_WINDOW cells holds the recent samples by age with a candidate
// flag each; a new sample clears the flags of the older samples it dominates and
// of those that leave the window, and shifts the row by one cell. The oldest
// flagged cell is the result, found by a registered select tree of
// clog2(MAX_WINDOW) levels (at least one); a result passes the cell row registers
// and then each tree level register. Throughput is one sample per cycle; an
// output stall holds the whole pipeline and stalls the input.
// result_valid is 0 and extreme_value is 0 until window_length samples of the
// series have arrived. Config writes are always ready and are registered before they take effect.
module sliding_window_min_max #(
	parameter int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [swmm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample,
	input  logic                               series_start,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]     extreme_value,
	output logic                               result_valid
);

	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int LEVELS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEAVES = 1 << LEVELS;

	logic [swmm_pkg::WINDOW_W-1:0] window_q;
	swmm_pkg::mode_t               mode_q;
	logic [WIN_W-1:0]              win;
	logic [WIN_W-1:0]              seen_q;
	logic [WIN_W-1:0]              seen_nxt;
	logic                          en;
	logic                          accept;
	logic                          v0_q;
	logic                          rv0_q;
	swmm_pkg::cell_ctrl_t          ctrl;

	logic                           kill    [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] sh_val  [MAX_WINDOW];
	logic                           sh_cand [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] cell_val  [MAX_WINDOW];
	logic                           cell_cand [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] leaf_val  [LEAVES];
	logic                           leaf_flag [LEAVES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swmm_pkg::WINDOW_W'(1);
			mode_q   <= swmm_pkg::MODE_MIN;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == swmm_pkg::CFG_WINDOW_LENGTH) begin
				window_q <= cfg_data[swmm_pkg::WINDOW_W-1:0];
			end else if (cfg_index == swmm_pkg::CFG_MODE) begin
				mode_q <= swmm_pkg::mode_t'(cfg_data[0]);
			end
		end
	end

	always_comb begin
		if (window_q == '0) begin
			win = WIN_W'(1);
		end else if (32'(window_q) > MAX_WINDOW) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(window_q);
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	always_comb begin
		if (series_start) begin
			seen_nxt = WIN_W'(1);
		end else if (32'(seen_q) < MAX_WINDOW) begin
			seen_nxt = seen_q + WIN_W'(1);
		end else begin
			seen_nxt = seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			v0_q   <= 1'b0;
		end else if (en) begin
			v0_q <= accept;
			if (accept) begin
				seen_q <= seen_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rv0_q <= (seen_nxt >= win);
		end
	end

	assign ctrl.load  = accept;
	assign ctrl.start = series_start;
	assign ctrl.mode  = mode_q;

	assign kill[0]    = 1'b1;
	assign sh_val[0]  = sample;
	assign sh_cand[0] = 1'b1;

	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		if (j < MAX_WINDOW - 1) begin : g_mid
			swmm_cell #(
				.SAMPLE_WIDTH (SAMPLE_WIDTH),
				.WIN_W        (WIN_W),
				.IDX          (j)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.win      (win),
				.sample   (sample),
				.d_val    (sh_val[j]),
				.d_cand   (sh_cand[j]),
				.kill_in  (kill[j]),
				.kill_out (kill[j+1]),
				.nxt_val  (sh_val[j+1]),
				.nxt_cand (sh_cand[j+1]),
				.val      (cell_val[j]),
				.cand     (cell_cand[j])
			);
		end else begin : g_last
			swmm_cell #(
				.SAMPLE_WIDTH (SAMPLE_WIDTH),
				.WIN_W        (WIN_W),
				.IDX          (j)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.win      (win),
				.sample   (sample),
				.d_val    (sh_val[j]),
				.d_cand   (sh_cand[j]),
				.kill_in  (kill[j]),
				.kill_out (),
				.nxt_val  (),
				.nxt_cand (),
				.val      (cell_val[j]),
				.cand     (cell_cand[j])
			);
		end
	end

	always_comb begin
		for (int k = 0; k < LEAVES; k++) begin
			if (k < MAX_WINDOW) begin
				leaf_flag[k] = cell_cand[k];
				leaf_val[k]  = cell_val[k];
			end else begin
				leaf_flag[k] = 1'b0;
				leaf_val[k]  = '0;
			end
		end
	end

	swmm_tree #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.LEVELS       (LEVELS),
		.LEAVES       (LEAVES)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (v0_q),
		.in_rv     (rv0_q),
		.leaf_flag (leaf_flag),
		.leaf_val  (leaf_val),
		.out_vld   (out_valid),
		.out_rv    (result_valid),
		.out_val   (extreme_value)
	);

endmodule
